FILE: hdl/dnfa_pkg.sv
package dnfa_pkg;

	localparam int POOL_ENTRIES = 1024;
	localparam int IDX_W        = $clog2(POOL_ENTRIES);
	localparam int CNT_W        = IDX_W + 1;
	localparam int WORD_W       = 32;
	localparam int BIT_W        = $clog2(WORD_W);
	localparam int WORDS        = POOL_ENTRIES / WORD_W;
	localparam int WADDR_W      = IDX_W - BIT_W;
	localparam int OP_W         = 2;

	typedef enum logic [OP_W-1:0] {
		OP_GET    = 2'd0,
		OP_MARK   = 2'd1,
		OP_REPACK = 2'd2,
		OP_RELOAD = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD   = 5'b00010,
		ST_GET  = 5'b00100,
		ST_MARK = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

endpackage

FILE: hdl/descending_next_fit_slot_allocator_top.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  opcode, slot_index
// rsp       out        rsp_valid/rsp_stall  ok, result_index, live_count
// cfg       in         cfg_we               cfg_wdata (pool_size)
//
// Repack, reload, a refused mark and a get with no free slot go straight to the finish state.
// A mark does one read of the bitmap word, then a write-back if the bit was clear.
// A get visits 1 to WORDS+1 bitmap words;
// each word is one read of the 32-bit word memory and one check.
// Reset clears a valid flop per map word, so no clearing pass follows reset.
// A result waiting on rsp_stall holds; the next item is still taken.
module descending_next_fit_slot_allocator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dnfa_pkg::CNT_W-1:0]  cfg_wdata,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [dnfa_pkg::OP_W-1:0]   opcode,
	input  logic [dnfa_pkg::IDX_W-1:0]  slot_index,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic                        ok,
	output logic [dnfa_pkg::IDX_W-1:0]  result_index,
	output logic [dnfa_pkg::CNT_W-1:0]  live_count
);
	import dnfa_pkg::*;

	state_t                    st_q;
	logic [CNT_W-1:0]          pool_size_q;
	logic [CNT_W-1:0]          slot_cnt_q;
	logic [CNT_W-1:0]          used_q;
	logic signed [CNT_W-1:0]   ptr_q;
	logic                      is_mark_q;
	logic [WADDR_W-1:0]        word_q;
	logic [BIT_W-1:0]          lim_q;
	logic                      res_ok_q;
	logic [IDX_W-1:0]          res_idx_q;
	logic                      rsp_valid_q;
	logic                      ok_q;
	logic [IDX_W-1:0]          result_index_q;
	logic [CNT_W-1:0]          live_count_q;
	logic [WORDS-1:0]          word_vld_q;

	logic [WORD_W-1:0]         map_mem [WORDS];
	logic [WORD_W-1:0]         mem_rdata_s1;
	logic                      rd_vld_s1;

	logic                      accept;
	logic                      rsp_free;
	logic                      free_remain;
	logic [CNT_W-1:0]          top_slot;
	logic [CNT_W-1:0]          reload_cnt;
	logic [CNT_W-1:0]          repack_cnt;
	logic                      mark_in_range;
	logic [IDX_W-1:0]          start_slot;
	logic                      mem_re;
	logic                      mem_we;
	logic [WORD_W-1:0]         mem_wdata;
	logic [WORD_W-1:0]         rd_word;
	logic [BIT_W-1:0]          mask_sh;
	logic [WORD_W-1:0]         lim_mask;
	logic [WORD_W-1:0]         cand;
	logic                      hit;
	logic [BIT_W-1:0]          hit_bit;
	logic [IDX_W-1:0]          found;
	logic signed [CNT_W-1:0]   found_ptr;
	logic                      mark_bit;

	assign accept      = req_valid && !req_stall;
	assign req_stall   = (st_q != ST_IDLE);
	assign rsp_free    = !rsp_valid_q || !rsp_stall;
	assign free_remain = (slot_cnt_q > used_q);
	assign top_slot    = slot_cnt_q - CNT_W'(1);
	assign reload_cnt  = (pool_size_q > CNT_W'(POOL_ENTRIES)) ? CNT_W'(POOL_ENTRIES)
							: pool_size_q;
	assign repack_cnt  = slot_cnt_q - used_q;
	assign mark_in_range = ({1'b0, slot_index} < slot_cnt_q) &&
							($signed({1'b0, slot_index}) > ptr_q);
	// below the bottom: restart from the top slot
	assign start_slot  = ptr_q[CNT_W-1] ? top_slot[IDX_W-1:0] : ptr_q[IDX_W-1:0];

	assign rd_word   = rd_vld_s1 ? mem_rdata_s1 : '0;
	assign mask_sh   = BIT_W'(WORD_W - 1) - lim_q;
	assign lim_mask  = {WORD_W{1'b1}} >> mask_sh;
	assign cand      = ~rd_word & lim_mask;
	assign hit       = |cand;
	assign found     = {word_q, hit_bit};
	assign found_ptr = $signed({1'b0, found}) - CNT_W'(1);
	assign mark_bit  = rd_word[lim_q];

	always_comb begin
		hit_bit = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (cand[i])
				hit_bit = BIT_W'(i);
		end
	end

	assign mem_re    = (st_q == ST_RD);
	assign mem_we    = (st_q == ST_MARK) && !mark_bit;
	assign mem_wdata = rd_word | (WORD_W'(1) << lim_q);

	always_ff @(posedge clk) begin
		if (mem_we)
			map_mem[word_q] <= mem_wdata;
		if (mem_re)
			mem_rdata_s1 <= map_mem[word_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= '0;
		end else if (cfg_we) begin
			pool_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			slot_cnt_q  <= '0;
			used_q      <= '0;
			ptr_q       <= '1;
			is_mark_q   <= 1'b0;
			word_q      <= '0;
			lim_q       <= '0;
			res_ok_q    <= 1'b0;
			res_idx_q   <= '0;
			word_vld_q  <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			if (mem_re)
				rd_vld_s1 <= word_vld_q[word_q];
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						res_ok_q  <= 1'b1;
						res_idx_q <= '0;
						st_q      <= ST_FIN;
						case (op_t'(opcode))
							OP_GET: begin
								if (!free_remain) begin
									res_ok_q <= 1'b0;
									ptr_q    <= '1;
								end else begin
									is_mark_q <= 1'b0;
									word_q    <= start_slot[IDX_W-1:BIT_W];
									lim_q     <= start_slot[BIT_W-1:0];
									st_q      <= ST_RD;
								end
							end
							OP_MARK: begin
								if (!mark_in_range) begin
									res_ok_q <= 1'b0;
								end else begin
									is_mark_q <= 1'b1;
									word_q    <= slot_index[IDX_W-1:BIT_W];
									lim_q     <= slot_index[BIT_W-1:0];
									st_q      <= ST_RD;
								end
							end
							OP_REPACK: begin
								slot_cnt_q <= repack_cnt;
								used_q     <= '0;
								word_vld_q <= '0;
								ptr_q      <= $signed(repack_cnt - CNT_W'(1));
							end
							default: begin
								slot_cnt_q <= reload_cnt;
								used_q     <= '0;
								word_vld_q <= '0;
								ptr_q      <= $signed(reload_cnt - CNT_W'(1));
							end
						endcase
					end
				end
				ST_RD: begin
					st_q <= is_mark_q ? ST_MARK : ST_GET;
				end
				ST_GET: begin
					if (hit) begin
						res_idx_q <= found;
						ptr_q     <= found_ptr;
						st_q      <= ST_FIN;
					end else if (word_q == '0) begin
						// wrap: a free slot is known to lie above the pointer
						word_q <= top_slot[IDX_W-1:BIT_W];
						lim_q  <= top_slot[BIT_W-1:0];
						st_q   <= ST_RD;
					end else begin
						word_q <= word_q - WADDR_W'(1);
						lim_q  <= '1;
						st_q   <= ST_RD;
					end
				end
				ST_MARK: begin
					if (!mark_bit) begin
						word_vld_q[word_q] <= 1'b1;
						used_q             <= used_q + CNT_W'(1);
					end
					st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (rsp_free)
						st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q    <= 1'b0;
			ok_q           <= 1'b0;
			result_index_q <= '0;
			live_count_q   <= '0;
		end else begin
			if (st_q == ST_FIN && rsp_free) begin
				rsp_valid_q    <= 1'b1;
				ok_q           <= res_ok_q;
				result_index_q <= res_idx_q;
				live_count_q   <= slot_cnt_q;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign ok           = ok_q;
	assign result_index = result_index_q;
	assign live_count   = live_count_q;

endmodule
